// ===== rtl/sjck_pkg.sv =====
// Shared types, mode bits and conversion functions of the Shift-JIS case and kana converter.
`default_nettype none

package sjck_pkg;

    // Mode register bit positions
    localparam int MODE_W         = 7;
    localparam int MODE_A_UP_BIT  = 0;
    localparam int MODE_A_LOW_BIT = 1;
    localparam int MODE_W_UP_BIT  = 2;
    localparam int MODE_W_LOW_BIT = 3;
    localparam int MODE_KATA_BIT  = 4;
    localparam int MODE_HIRA_BIT  = 5;
    localparam int MODE_SPACE_BIT = 6;

    // Default depth of the queue between front and back
    localparam int SJCK_QUEUE_DEPTH = 4;

    // Lead byte values of the two-byte pages that get rewritten
    localparam logic [7:0] LEAD_SYMBOL = 8'h81;
    localparam logic [7:0] LEAD_HIRA   = 8'h82;
    localparam logic [7:0] LEAD_KATA   = 8'h83;
    localparam logic [7:0] WIDE_SPACE  = 8'h40;
    localparam logic [7:0] ASCII_SPACE = 8'h20;

    typedef logic [MODE_W-1:0] mode_t;

    // One queued unit of work: a single byte or a two-byte character
    typedef struct packed {
        logic       pair;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       last;
    } sjck_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } sjck_qstat_t;

    function automatic logic is_lead(input logic [7:0] c);
        is_lead = (c inside {[8'h81:8'h9F], [8'hE0:8'hFC]});
    endfunction

    function automatic logic [7:0] convert_single(input mode_t mode, input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if ((c inside {[8'h41:8'h5A]}) && mode[MODE_A_LOW_BIT])
            r = c + 8'h20;
        else if ((c inside {[8'h61:8'h7A]}) && mode[MODE_A_UP_BIT])
            r = c - 8'h20;
        convert_single = r;
    endfunction

    // Returns {hi, lo} of the rewritten two-byte character
    function automatic logic [15:0] convert_pair(input mode_t mode, input logic [7:0] c,
                                                 input logic [7:0] d);
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] t;
        hi = c;
        lo = d;
        t  = 8'h00;
        if (d == 8'h00) begin
            hi = 8'h00;
        end else if (c == LEAD_SYMBOL) begin
            if (d == WIDE_SPACE && mode[MODE_SPACE_BIT]) begin
                hi = ASCII_SPACE;
                lo = ASCII_SPACE;
            end
        end else if (c == LEAD_HIRA) begin
            if (d inside {[8'h60:8'h79]}) begin
                if (mode[MODE_W_LOW_BIT])
                    lo = d + 8'h21;
            end else if (d inside {[8'h81:8'h9A]}) begin
                if (mode[MODE_W_UP_BIT])
                    lo = d - 8'h21;
            end else if (d inside {[8'h9F:8'hF1]}) begin
                if (mode[MODE_KATA_BIT]) begin
                    t  = d - 8'h5F;
                    hi = LEAD_KATA;
                    lo = (t > 8'h7E) ? t + 8'h01 : t;
                end
            end
        end else if (c == LEAD_KATA && (d inside {[8'h40:8'h93]})) begin
            if (mode[MODE_HIRA_BIT]) begin
                t  = (d > 8'h7E) ? d - 8'h01 : d;
                hi = LEAD_HIRA;
                lo = t + 8'h5F;
            end
        end
        convert_pair = {hi, lo};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sjck_front.sv =====
// Front part: accepts input bytes, pairs lead and trail bytes and converts them.
`default_nettype none

module sjck_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sjck_pkg::mode_t      mode,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [7:0]           text_byte,
    input  wire logic                 end_of_string,
    input  wire sjck_pkg::sjck_qstat_t qstat,
    output logic                      push,
    output sjck_pkg::sjck_entry_t     push_entry
);
    import sjck_pkg::*;

    logic       lead_pending_reg;
    logic       lead_pending_next;
    logic [7:0] held_lead_reg;
    logic [7:0] held_lead_next;
    logic       accept;
    logic [15:0] pair_bytes;

    assign in_ready   = ~qstat.full;
    assign accept     = in_valid & in_ready;
    assign pair_bytes = convert_pair(mode, held_lead_reg, text_byte);

    // Classify the item: trail, lead (held or truncated), or single byte
    always_comb
    begin
        lead_pending_next = lead_pending_reg;
        held_lead_next    = held_lead_reg;
        push              = 1'b0;
        push_entry.pair   = 1'b0;
        push_entry.byte0  = convert_single(mode, text_byte);
        push_entry.byte1  = pair_bytes[7:0];
        push_entry.last   = end_of_string;
        if (accept) begin
            if (lead_pending_reg) begin
                push              = 1'b1;
                push_entry.pair   = 1'b1;
                push_entry.byte0  = pair_bytes[15:8];
                lead_pending_next = 1'b0;
                held_lead_next    = 8'h00;
            end else if (is_lead(text_byte)) begin
                if (end_of_string) begin
                    push             = 1'b1;
                    push_entry.byte0 = 8'h00;
                end else begin
                    lead_pending_next = 1'b1;
                    held_lead_next    = text_byte;
                end
            end else begin
                push = 1'b1;
            end
        end
    end

    // Hold the lead byte until its trail arrives
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            lead_pending_reg <= 1'b0;
            held_lead_reg    <= 8'h00;
        end else begin
            lead_pending_reg <= lead_pending_next;
            held_lead_reg    <= held_lead_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sjck_queue.sv =====
// Short queue of converted entries between the front and back parts.
`default_nettype none

module sjck_queue #(
    parameter int DEPTH = sjck_pkg::SJCK_QUEUE_DEPTH
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire sjck_pkg::sjck_entry_t push_entry,
    input  wire logic                  pop,
    output sjck_pkg::sjck_entry_t      pop_entry,
    output sjck_pkg::sjck_qstat_t      qstat
);
    import sjck_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sjck_entry_t        slots [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign qstat.full  = (count_reg == CNT_W'(DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign pop_entry   = slots[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

// ===== rtl/sjck_back.sv =====
// Back part: splits queued entries into output bytes behind an output register.
`default_nettype none

module sjck_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sjck_pkg::sjck_qstat_t qstat,
    input  wire sjck_pkg::sjck_entry_t pop_entry,
    output logic                       pop,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [7:0]                 out_byte,
    output logic                       out_last
);
    import sjck_pkg::*;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic [7:0] out_byte_next;
    logic       out_last_reg;
    logic       out_last_next;
    logic       sec_pending_reg;
    logic       sec_pending_next;
    logic [7:0] sec_byte_reg;
    logic [7:0] sec_byte_next;
    logic       sec_last_reg;
    logic       sec_last_next;
    logic       slot_free;

    assign slot_free = ~out_valid_reg | out_ready;
    assign pop       = slot_free & ~sec_pending_reg & ~qstat.empty;

    // Load the output register from the second byte or the queue head
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_byte_next    = out_byte_reg;
        out_last_next    = out_last_reg;
        sec_pending_next = sec_pending_reg;
        sec_byte_next    = sec_byte_reg;
        sec_last_next    = sec_last_reg;
        if (slot_free) begin
            if (sec_pending_reg) begin
                out_valid_next   = 1'b1;
                out_byte_next    = sec_byte_reg;
                out_last_next    = sec_last_reg;
                sec_pending_next = 1'b0;
            end else if (!qstat.empty) begin
                out_valid_next   = 1'b1;
                out_byte_next    = pop_entry.byte0;
                out_last_next    = pop_entry.last & ~pop_entry.pair;
                sec_pending_next = pop_entry.pair;
                sec_byte_next    = pop_entry.byte1;
                sec_last_next    = pop_entry.last;
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg   <= 1'b0;
            sec_pending_reg <= 1'b0;
        end else begin
            out_valid_reg   <= out_valid_next;
            sec_pending_reg <= sec_pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        sec_byte_reg <= sec_byte_next;
        sec_last_reg <= sec_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/shift_jis_case_kana_converter_core.sv =====
// Top level of the Shift-JIS case and kana converter.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------
//   input    | in_valid / in_ready  | text_byte, end_of_string
//   output   | out_valid / out_ready| out_byte, out_last
//   config   | cfg_we               | cfg_wdata (conversion mode)
//
// One input item is taken per cycle while the entry queue has room.
// A single byte is written to the entry queue and then to the output register;
// a trail byte yields two output bytes, which leave one after the other through
// the single output register. A lead byte yields nothing until its trail arrives,
// or a 00 byte if it ends the string. Reset clears the held lead, the queue and
// the output register. Output stalls fill the queue and then drop in_ready.
`default_nettype none

module shift_jis_case_kana_converter_core #(
    parameter int QUEUE_DEPTH = sjck_pkg::SJCK_QUEUE_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [6:0] cfg_wdata,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] text_byte,
    input  wire logic       end_of_string,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            out_last
);
    import sjck_pkg::*;

    mode_t       mode_reg;
    sjck_qstat_t qstat;
    sjck_entry_t push_entry;
    sjck_entry_t pop_entry;
    logic        push;
    logic        pop;

    // Hold the conversion mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= '0;
        else if (cfg_we)
            mode_reg <= cfg_wdata;
    end

    sjck_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .mode          (mode_reg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .text_byte     (text_byte),
        .end_of_string (end_of_string),
        .qstat         (qstat),
        .push          (push),
        .push_entry    (push_entry)
    );

    sjck_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .qstat      (qstat)
    );

    sjck_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qstat     (qstat),
        .pop_entry (pop_entry),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

endmodule

`default_nettype wire

// ===== rtl/sjck_checker.sv =====
// Port-level checks of the converter core and their binding.
`default_nettype none

module sjck_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       cfg_we,
    input wire logic [6:0] cfg_wdata,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic [7:0] text_byte,
    input wire logic       end_of_string,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       out_last
);

    // A stalled output item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
        else $error("output item changed while stalled");

    // Reset empties the block and opens the input
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid && in_ready)
        else $error("block not empty after reset");

    // Input backpressure only comes from a held output item
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no output pending");

endmodule

bind shift_jis_case_kana_converter_core sjck_checker u_sjck_checker (.*);

`default_nettype wire
